[rtl/ffq_pkg.sv]
package ffq_pkg;

  // Operation codes carried on func_i
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CAPACITY = 1'b0,
    CFG_POLICY   = 1'b1
  } cfg_idx_e;

  // Overflow policy codes
  typedef enum logic [0:0] {
    POLICY_DROP_OLDEST = 1'b0,
    POLICY_DROP_NEWEST = 1'b1
  } policy_e;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 9;

endpackage

[rtl/ffq_ram.sv]
module ffq_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write one frame slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/frame_fifo_with_overflow_policy_top.sv]
// Channel  | Direction | Signals                                   | Handshake
// ---------+-----------+-------------------------------------------+--------------------------
// request  | in        | func_i, data_in_i                         | start_i high, busy_o low
// result   | out       | ok_o, data_out_o, occupancy_o, *_total_o  | done_o, one cycle, no stall
// config   | in        | cfg_idx_i, cfg_wdata_i                    | cfg_we_i
//
// Every request is accepted while start_i is high and its result shows with
// done_o in the next cycle; busy_o stays low, so one request may enter each
// cycle. The frame RAM (one read or one write per request, registered read)
// allows that rate. Reset clears pointers, occupancy and counters;
// the frame RAM is not cleared, since a slot is read only after it was written.
// The receiver cannot stall; results are shown once and then replaced.
module frame_fifo_with_overflow_policy_top #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned FRAME_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ffq_pkg::FUNC_W-1:0]    func_i,
  input  logic [ffq_pkg::DATA_W-1:0]    data_in_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [ffq_pkg::DATA_W-1:0]    data_out_o,
  output logic [ffq_pkg::CAP_W-1:0]     occupancy_o,
  output logic [ffq_pkg::CNT_W-1:0]     dropped_total_o,
  output logic [ffq_pkg::CNT_W-1:0]     pushed_total_o,
  output logic [ffq_pkg::CNT_W-1:0]     popped_total_o,
  input  logic                          cfg_we_i,
  input  logic [ffq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffq_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import ffq_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned SW      = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam int unsigned CAP_MAX = (DEPTH > (2 ** CAP_W - 1)) ? (2 ** CAP_W - 1) : DEPTH;
  localparam int unsigned CAP_RST = (DEPTH < 256) ? DEPTH : 256;

  // Architectural state
  logic [AW-1:0]    head_q, head_d;
  logic [CAP_W-1:0] held_q, held_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic             policy_q;
  logic [CNT_W-1:0] drop_cnt_q, drop_cnt_d;
  logic [CNT_W-1:0] push_cnt_q, push_cnt_d;
  logic [CNT_W-1:0] pop_cnt_q, pop_cnt_d;

  // Result stage
  logic done_q;
  logic ok_q, ok_d;
  logic pop_ok_q, pop_ok_d;

  // RAM request
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [FRAME_BITS-1:0] ram_rdata;

  logic          accept;
  logic          full;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] head_inc;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] head_next;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (held_q == cap_q);

  // Wrap slot indexes by compare and subtract against the capacity
  always_comb begin
    tail_sum = SW'(head_q) + SW'(held_q);
    if (tail_sum >= SW'(cap_q)) begin
      tail_sum = tail_sum - SW'(cap_q);
    end
    tail_idx = tail_sum[AW-1:0];
    head_inc = SW'(head_q) + SW'(1);
    if (head_inc >= SW'(cap_q)) begin
      head_inc = head_inc - SW'(cap_q);
    end
    head_next = head_inc[AW-1:0];
  end

  // Decode the request and plan state updates and the RAM access
  always_comb begin
    head_d     = head_q;
    held_d     = held_q;
    drop_cnt_d = drop_cnt_q;
    push_cnt_d = push_cnt_q;
    pop_cnt_d  = pop_cnt_q;
    ok_d       = 1'b0;
    pop_ok_d   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail_idx;
    ram_re     = 1'b0;
    if (accept) begin
      case (func_e'(func_i))
        FUNC_PUSH: begin
          if (full) begin
            drop_cnt_d = drop_cnt_q + CNT_W'(1);
            if (policy_q == POLICY_DROP_OLDEST) begin
              ram_we     = 1'b1;
              ram_waddr  = head_q;
              head_d     = head_next;
              push_cnt_d = push_cnt_q + CNT_W'(1);
              ok_d       = 1'b1;
            end
          end else begin
            ram_we     = 1'b1;
            held_d     = held_q + CAP_W'(1);
            push_cnt_d = push_cnt_q + CNT_W'(1);
            ok_d       = 1'b1;
          end
        end
        FUNC_POP: begin
          if (held_q != '0) begin
            ram_re    = 1'b1;
            head_d    = head_next;
            held_d    = held_q - CAP_W'(1);
            pop_cnt_d = pop_cnt_q + CNT_W'(1);
            ok_d      = 1'b1;
            pop_ok_d  = 1'b1;
          end
        end
        FUNC_FLUSH: begin
          head_d = '0;
          held_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp a capacity write to the built depth, at most 511; zero reads as one
  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_CAPACITY)) begin
      if (cfg_wdata_i[CAP_W-1:0] == '0) begin
        cap_d = CAP_W'(1);
      end else if (cfg_wdata_i[CAP_W-1:0] > CAP_W'(CAP_MAX)) begin
        cap_d = CAP_W'(CAP_MAX);
      end else begin
        cap_d = cfg_wdata_i[CAP_W-1:0];
      end
    end
  end

  // Update state; a capacity write also empties the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      held_q     <= '0;
      cap_q      <= CAP_W'(CAP_RST);
      policy_q   <= POLICY_DROP_OLDEST;
      drop_cnt_q <= '0;
      push_cnt_q <= '0;
      pop_cnt_q  <= '0;
      done_q     <= 1'b0;
      ok_q       <= 1'b0;
      pop_ok_q   <= 1'b0;
    end else begin
      cap_q      <= cap_d;
      drop_cnt_q <= drop_cnt_d;
      push_cnt_q <= push_cnt_d;
      pop_cnt_q  <= pop_cnt_d;
      done_q     <= accept;
      ok_q       <= ok_d;
      pop_ok_q   <= pop_ok_d;
      if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_CAPACITY)) begin
        head_q <= '0;
        held_q <= '0;
      end else begin
        head_q <= head_d;
        held_q <= held_d;
      end
      if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_POLICY)) begin
        policy_q <= cfg_wdata_i[0];
      end
    end
  end

  ffq_ram #(
    .Depth (DEPTH),
    .Width (FRAME_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_in_i[FRAME_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Drive the result; frame data only for a successful pop
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign data_out_o      = pop_ok_q ? DATA_W'(ram_rdata) : '0;
  assign occupancy_o     = held_q;
  assign dropped_total_o = drop_cnt_q;
  assign pushed_total_o  = push_cnt_q;
  assign popped_total_o  = pop_cnt_q;

  // Occupancy never exceeds the capacity in use
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= cap_q)
    else $error("occupancy above capacity");

  // Head slot stays inside the capacity in use
  assert property (@(posedge clk_i) disable iff (!rst_ni) SW'(head_q) < SW'(cap_q))
    else $error("head slot outside capacity");

  // Every accepted request yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> done_o)
    else $error("missing result strobe");

  // A push counts toward the push total exactly when it reports success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == FUNC_PUSH) |=> (pushed_total_o != $past(pushed_total_o)) == ok_o)
    else $error("push total out of step with push result");

  // A pop with frames held must succeed and shrink the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && (func_i == FUNC_POP) && (held_q != '0)
    |=> ok_o && (occupancy_o == $past(held_q) - CAP_W'(1)))
    else $error("pop on non-empty queue failed");

endmodule
